// File: src/cslcm_pkg.sv
// Package for the component size lcm unit: sizes, state codes and the
// command and status structs between controller and datapath.
// Depends on nothing.
package cslcm_pkg;

	localparam int MAX_ENTRIES = 256;
	localparam int NODE_W      = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = NODE_W + 1;
	localparam int TGT_W       = 9;
	localparam int LCM_W       = 63;
	localparam int PROD_W      = LCM_W + CNT_W;
	localparam int STEP_W      = $clog2(LCM_W);
	localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_ENTRIES);
	localparam logic [LCM_W-1:0]  LCM_LIMIT = {LCM_W{1'b1}};
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(LCM_W - 1);

	typedef enum logic [3:0] {
		S_LOAD,
		S_CLR,
		S_NEXT,
		S_VISW,
		S_POP,
		S_POPW,
		S_TGTW,
		S_TGTV,
		S_SCAN,
		S_FOLD,
		S_FWAIT,
		S_OUT
	} ctrl_state_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_DIV1,
		F_GCD,
		F_DIV2,
		F_MUL,
		F_CHK
	} fold_state_t;

	typedef struct packed {
		logic load;
		logic clr_list;
		logic vis_clr;
		logic vis_start;
		logic i_inc;
		logic pop;
		logic lat_u;
		logic tgt_rd;
		logic push_tgt;
		logic scan_init;
		logic scan;
		logic fold_start;
	} cslcm_cmd_t;

	typedef struct packed {
		logic i_end;
		logic clr_end;
		logic vis_i;
		logic sp_zero;
		logic u_lt;
		logic scan_done;
		logic fold_busy;
	} cslcm_sts_t;

endpackage

// File: src/cslcm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module cslcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/cslcm_fold.sv
// Lcm fold unit: lcm = lcm / gcd(lcm, b) * b with saturation.
// Bit-serial divider, subtractive gcd, one registered multiply.
// Depends on cslcm_pkg.
module cslcm_fold (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      clear,
	input  logic [cslcm_pkg::CNT_W-1:0] b,
	output logic                      busy,
	output logic [cslcm_pkg::LCM_W-1:0] lcm,
	output logic                      ovf
);
	import cslcm_pkg::*;

	fold_state_t state_q, state_d;
	logic [LCM_W-1:0]  lcm_q;
	logic              ovf_q;
	logic [CNT_W-1:0]  b_q, d_q, rem_q, x_q, y_q;
	logic [LCM_W-1:0]  qr_q;
	logic [STEP_W-1:0] cnt_q;
	logic [PROD_W-1:0] prod_s1;
	logic [CNT_W:0]    rem_n;
	logic              ge;
	logic [CNT_W-1:0]  rem_next;
	logic [LCM_W-1:0]  qr_next;

	always_comb begin
		rem_n    = {rem_q, qr_q[LCM_W-1]};
		ge       = rem_n >= {1'b0, d_q};
		rem_next = ge ? CNT_W'(rem_n - {1'b0, d_q}) : rem_n[CNT_W-1:0];
		qr_next  = {qr_q[LCM_W-2:0], ge};
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: if (start && !ovf_q) state_d = F_DIV1;
			F_DIV1: if (cnt_q == LAST_STEP) state_d = F_GCD;
			F_GCD:  if (y_q == '0) state_d = F_DIV2;
			F_DIV2: if (cnt_q == LAST_STEP) state_d = F_MUL;
			F_MUL:  state_d = F_CHK;
			F_CHK:  state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			lcm_q   <= LCM_W'(1);
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == F_IDLE && clear) begin
				lcm_q <= LCM_W'(1);
				ovf_q <= 1'b0;
			end else if (state_q == F_CHK) begin
				if (prod_s1[PROD_W-1:LCM_W] != '0) begin
					lcm_q <= LCM_LIMIT;
					ovf_q <= 1'b1;
				end else begin
					lcm_q <= prod_s1[LCM_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				b_q   <= b;
				d_q   <= b;
				qr_q  <= lcm_q;
				rem_q <= '0;
				cnt_q <= '0;
			end
			F_DIV1: begin
				rem_q <= rem_next;
				qr_q  <= qr_next;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					x_q <= b_q;
					y_q <= rem_next;
				end
			end
			F_GCD: begin
				if (y_q == '0) begin
					d_q   <= x_q;
					qr_q  <= lcm_q;
					rem_q <= '0;
					cnt_q <= '0;
				end else if (x_q >= y_q) begin
					x_q <= x_q - y_q;
				end else begin
					x_q <= y_q;
					y_q <= x_q;
				end
			end
			F_DIV2: begin
				rem_q <= rem_next;
				qr_q  <= qr_next;
				cnt_q <= cnt_q + 1'b1;
			end
			F_MUL:  prod_s1 <= PROD_W'(qr_q) * PROD_W'(b_q);
			F_CHK:  ;
			default: ;
		endcase
	end

	assign busy = state_q != F_IDLE;
	assign lcm  = lcm_q;
	assign ovf  = ovf_q;

endmodule

// File: src/cslcm_dpath.sv
// Datapath: target, walk-stack and visited-map memories, walk counters,
// and the lcm fold unit.
// Depends on cslcm_pkg, cslcm_ram and cslcm_fold.
module cslcm_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cslcm_pkg::cslcm_cmd_t       cmd,
	output cslcm_pkg::cslcm_sts_t       sts,
	input  logic [cslcm_pkg::TGT_W-1:0] target_index,
	output logic [cslcm_pkg::LCM_W-1:0] order_value,
	output logic                        overflow
);
	import cslcm_pkg::*;

	logic [CNT_W-1:0]       count_q, i_q, sp_q, size_q, j_q;
	logic [NODE_W-1:0]      u_q, j_s1;
	logic                   p_s1;
	logic [NODE_W-1:0]      trg_rd, stk_rd, trg_raddr, trg_wdata, push_node;
	logic                   trg_we, push, scan_hit, in_range;
	logic                   stk_we;
	logic [NODE_W-1:0]      stk_waddr, stk_wdata;
	logic                   vis_we, vis_wdata, vis_rd;
	logic [NODE_W-1:0]      vis_waddr, vis_raddr;
	logic [CNT_W-1:0]       sp_dec;
	logic                   clr_end;
	logic                   fold_busy;

	assign in_range  = target_index != '0 && CNT_W'(target_index) <= MAX_CNT;
	assign trg_we    = cmd.load && count_q < MAX_CNT;
	assign trg_wdata = in_range ? NODE_W'(target_index - 1'b1) : count_q[NODE_W-1:0];
	assign trg_raddr = cmd.scan ? j_q[NODE_W-1:0] : (cmd.lat_u ? stk_rd : u_q);
	assign vis_raddr = cmd.scan ? j_q[NODE_W-1:0] : (cmd.tgt_rd ? trg_rd : i_q[NODE_W-1:0]);
	assign sp_dec    = sp_q - 1'b1;
	assign clr_end   = i_q == MAX_CNT - 1'b1;

	assign scan_hit = cmd.scan && p_s1 && trg_rd == u_q && !vis_rd;

	always_comb begin
		push      = 1'b0;
		push_node = j_s1;
		if (cmd.push_tgt) begin
			push      = !vis_rd;
			push_node = trg_rd;
		end else if (scan_hit) begin
			push = 1'b1;
		end
		stk_we    = push || cmd.vis_start;
		stk_waddr = cmd.vis_start ? '0 : sp_q[NODE_W-1:0];
		stk_wdata = cmd.vis_start ? i_q[NODE_W-1:0] : push_node;
		vis_we    = push || cmd.vis_start || cmd.vis_clr;
		vis_waddr = push ? push_node : i_q[NODE_W-1:0];
		vis_wdata = !cmd.vis_clr;
	end

	cslcm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_ENTRIES)) u_trg (
		.clk   (clk),
		.we    (trg_we),
		.waddr (count_q[NODE_W-1:0]),
		.wdata (trg_wdata),
		.raddr (trg_raddr),
		.rdata (trg_rd)
	);

	cslcm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_ENTRIES)) u_stk (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (sp_dec[NODE_W-1:0]),
		.rdata (stk_rd)
	);

	cslcm_ram #(.WIDTH(1), .DEPTH(MAX_ENTRIES)) u_vis (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_waddr),
		.wdata (vis_wdata),
		.raddr (vis_raddr),
		.rdata (vis_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			i_q     <= '0;
			sp_q    <= '0;
			size_q  <= '0;
			j_q     <= '0;
			p_s1    <= 1'b0;
		end else begin
			if (cmd.clr_list) begin
				count_q <= '0;
				i_q     <= '0;
			end
			if (trg_we) count_q <= count_q + 1'b1;
			if (cmd.i_inc) i_q <= i_q + 1'b1;
			if (cmd.vis_clr) i_q <= clr_end ? '0 : i_q + 1'b1;
			if (cmd.vis_start) begin
				sp_q   <= CNT_W'(1);
				size_q <= '0;
			end
			if (cmd.pop) begin
				sp_q   <= sp_dec;
				size_q <= size_q + 1'b1;
			end
			if (push) begin
				sp_q <= sp_q + 1'b1;
			end
			if (cmd.scan_init) begin
				j_q  <= '0;
				p_s1 <= 1'b0;
			end
			if (cmd.scan) begin
				if (j_q < count_q) begin
					p_s1 <= 1'b1;
					j_q  <= j_q + 1'b1;
				end else begin
					p_s1 <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lat_u) u_q <= stk_rd;
		if (cmd.scan) j_s1 <= j_q[NODE_W-1:0];
	end

	cslcm_fold u_fold (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.fold_start),
		.clear  (cmd.clr_list),
		.b      (size_q),
		.busy   (fold_busy),
		.lcm    (order_value),
		.ovf    (overflow)
	);

	always_comb begin
		sts.i_end     = i_q == count_q;
		sts.clr_end   = clr_end;
		sts.vis_i     = vis_rd;
		sts.sp_zero   = sp_q == '0;
		sts.u_lt      = CNT_W'(stk_rd) < count_q;
		sts.scan_done = j_q == count_q && !p_s1;
		sts.fold_busy = fold_busy;
	end

endmodule

// File: src/cslcm_ctrl.sv
// Controller: loads the list, walks each component and sequences the fold.
// Depends on cslcm_pkg.
module cslcm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  last_entry,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  cslcm_pkg::cslcm_sts_t sts,
	output cslcm_pkg::cslcm_cmd_t cmd
);
	import cslcm_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			S_LOAD: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (last_entry) state_d = S_CLR;
				end
			end
			S_CLR: begin
				cmd.vis_clr = 1'b1;
				if (sts.clr_end) state_d = S_NEXT;
			end
			S_NEXT: begin
				if (sts.i_end) begin
					state_d = S_OUT;
				end else begin
					state_d = S_VISW;
				end
			end
			S_VISW: begin
				if (sts.vis_i) begin
					cmd.i_inc = 1'b1;
					state_d = S_NEXT;
				end else begin
					cmd.vis_start = 1'b1;
					state_d = S_POP;
				end
			end
			S_POP: begin
				if (sts.sp_zero) begin
					state_d = S_FOLD;
				end else begin
					cmd.pop = 1'b1;
					state_d = S_POPW;
				end
			end
			S_POPW: begin
				cmd.lat_u = 1'b1;
				if (sts.u_lt) begin
					state_d = S_TGTW;
				end else begin
					cmd.scan_init = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_TGTW: begin
				cmd.tgt_rd = 1'b1;
				state_d = S_TGTV;
			end
			S_TGTV: begin
				cmd.push_tgt  = 1'b1;
				cmd.scan_init = 1'b1;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) state_d = S_POP;
			end
			S_FOLD: begin
				cmd.fold_start = 1'b1;
				state_d = S_FWAIT;
			end
			S_FWAIT: begin
				if (!sts.fold_busy) begin
					cmd.i_inc = 1'b1;
					state_d = S_NEXT;
				end
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					cmd.clr_list = 1'b1;
					state_d = S_LOAD;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

endmodule

// File: src/component_size_lcm_unit.sv
// Top level of the component size lcm unit: controller plus datapath.
// Depends on cslcm_pkg, cslcm_ctrl and cslcm_dpath.
//
// Entries load one per cycle. After the entry marked last, the block stalls
// its input, clears all 256 entries of the visited map, then walks the
// graph and folds component sizes into the lcm. Per popped node the walk
// reads the node's target and scans the whole list through the target
// memory read port. Each component size is folded in by the bit-serial
// divider, run twice, the subtractive gcd and one registered multiply.
// The result transaction is held until taken; the next list then loads.
module component_size_lcm_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [cslcm_pkg::TGT_W-1:0] target_index,
	input  logic                        last_entry,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [cslcm_pkg::LCM_W-1:0] order_value,
	output logic                        overflow
);
	import cslcm_pkg::*;

	cslcm_cmd_t cmd;
	cslcm_sts_t sts;

	cslcm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.last_entry (last_entry),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	cslcm_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.target_index (target_index),
		.order_value  (order_value),
		.overflow     (overflow)
	);

endmodule
